@@ rtl/core/dwt_pkg.sv @@
// Shared types and constants for the dirty window tracker.
// No dependencies; compiled first.
package dwt_pkg;

  localparam int DWT_MAX_WIDTH  = 320;
  localparam int DWT_MAX_HEIGHT = 320;
  localparam int DWT_PAGE_BYTES = 2048;

  localparam int CFG_W  = 9;
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 9'd320;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 9'd240;

  typedef enum logic [CFG_AW-3:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_ROW_OFFSET   = 3'd2,
    REG_COL_OFFSET   = 3'd3,
    REG_DEPTH_MODE   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] pixel_unit;
  } in_item_t;

  typedef struct packed {
    logic [9:0] row_start;
    logic [9:0] row_end;
    logic [9:0] col_start;
    logic [9:0] col_end;
  } out_item_t;

endpackage

@@ rtl/core/dwt_stream_if.sv @@
// Valid/ready stream channel with a typed payload.
// Payload types come from dwt_pkg at the point of instantiation.
interface dwt_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/dirty_window_tracker_unit.sv @@
// Dirty window tracker top level: shadow compare, dirty box and window emit.
// Depends on dwt_pkg, dwt_stream_if and dwt_ram.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+-------------------------------------
//   in_ch    | in  | valid/ready       | pixel_unit[31:0]
//   out_ch   | out | valid/ready       | row_start, row_end, col_start, col_end
//   apb      | in  | psel/penable      | paddr[4:2] index, pwdata[8:0]
//
// One unit per cycle. A unit reads both shadow banks on transfer, compares and
// writes back the next cycle; the prior write is forwarded. A row-end unit waits
// while the previous row end's window check (merge, divide, multiply-compare)
// is in flight, so short rows can stall at each row end; a stalled result holds
// that check. After reset a clearing pass writes ones to all MEM_DEPTH entries
// (76800 by default) of both shadow banks, with no transfer accepted.
module dirty_window_tracker_unit #(
  parameter int MAX_WIDTH  = dwt_pkg::DWT_MAX_WIDTH,
  parameter int MAX_HEIGHT = dwt_pkg::DWT_MAX_HEIGHT,
  parameter int PAGE_BYTES = dwt_pkg::DWT_PAGE_BYTES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  dwt_stream_if.sink                 in_ch,
  dwt_stream_if.source               out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dwt_pkg::CFG_AW-1:0] paddr,
  input  logic [dwt_pkg::CFG_DW-1:0] pwdata,
  output logic [dwt_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import dwt_pkg::*;

  localparam int WCAP      = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
  localparam int WL        = (WCAP / 2) * 2;
  localparam int UPR_MAX   = (WL * 3) / 2;
  localparam int HL        = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
  localparam int UW        = $clog2(UPR_MAX + 1);
  localparam int RW        = $clog2(HL + 1);
  localparam int EW        = $clog2(WL + 1);
  localparam int POS_N     = UPR_MAX * HL;
  localparam int PW        = $clog2(POS_N);
  localparam int MEM_DEPTH = (POS_N + 1) / 2;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int DW        = UW + 2;
  localparam int DS        = DW + 1;
  localparam logic [DS-1:0] K3 = DS'(((2 ** DS) + 2) / 3);
  localparam int BW        = UW + RW + 2;
  localparam int CMPW      = (BW > 17) ? BW : 17;

  function automatic logic [DW-1:0] div3(input logic [DW-1:0] x);
    logic [DW+DS-1:0] p;
    p = (DW + DS)'(x) * (DW + DS)'(K3);
    return p[DS +: DW];
  endfunction

  // configuration
  logic [CFG_W-1:0] frame_width_r, frame_height_r, row_offset_r, col_offset_r;
  logic             depth_mode_r;
  logic             cfg_wr, restart;
  logic [CFG_AW-3:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[CFG_AW-1:2];
  assign restart = cfg_wr && (cfg_idx == REG_FRAME_WIDTH || cfg_idx == REG_FRAME_HEIGHT ||
                              cfg_idx == REG_DEPTH_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      row_offset_r   <= '0;
      col_offset_r   <= '0;
      depth_mode_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width_r  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[CFG_W-1:0];
        REG_ROW_OFFSET:   row_offset_r   <= pwdata[CFG_W-1:0];
        REG_COL_OFFSET:   col_offset_r   <= pwdata[CFG_W-1:0];
        REG_DEPTH_MODE:   depth_mode_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = CFG_DW'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = CFG_DW'(frame_height_r);
      REG_ROW_OFFSET:   prdata = CFG_DW'(row_offset_r);
      REG_COL_OFFSET:   prdata = CFG_DW'(col_offset_r);
      REG_DEPTH_MODE:   prdata = CFG_DW'(depth_mode_r);
      default:          prdata = '0;
    endcase
  end

  // effective geometry
  logic [9:0]    w_cap, h_cap;
  logic [EW-1:0] eff_w;
  logic [RW-1:0] eff_h;
  logic [UW-1:0] upr;

  always_comb begin
    w_cap = ({1'b0, frame_width_r} > 10'(WCAP)) ? 10'(WCAP) : {1'b0, frame_width_r};
    w_cap = {w_cap[9:1], 1'b0};
    if (w_cap < 10'd2) begin
      w_cap = 10'd2;
    end
    eff_w = EW'(w_cap);
    h_cap = ({1'b0, frame_height_r} > 10'(HL)) ? 10'(HL) : {1'b0, frame_height_r};
    if (h_cap == 10'd0) begin
      h_cap = 10'd1;
    end
    eff_h = RW'(h_cap);
    upr   = depth_mode_r ? (UW'(eff_w) + UW'(eff_w >> 1)) : UW'(eff_w >> 1);
  end

  // clearing pass
  logic          clr_done_r;
  logic [AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_done_r <= 1'b0;
      clr_cnt_r  <= '0;
    end else if (!clr_done_r) begin
      if (clr_cnt_r == AW'(MEM_DEPTH - 1)) begin
        clr_done_r <= 1'b1;
      end else begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // raster position
  logic [UW-1:0] unit_r;
  logic [RW-1:0] row_r;
  logic [PW-1:0] pos_r, pos_half;
  logic          row_end_in, frame_end_in, accept, chk_busy;
  logic [AW-1:0] rd_addr;

  assign row_end_in   = (unit_r == upr - 1'b1);
  assign frame_end_in = row_end_in && (row_r == eff_h - 1'b1);
  assign in_ch.ready  = clr_done_r && !(row_end_in && chk_busy);
  assign accept       = in_ch.valid && in_ch.ready;
  assign pos_half     = pos_r >> 1;
  assign rd_addr      = depth_mode_r ? pos_half[AW-1:0] : pos_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      unit_r <= '0;
      row_r  <= '0;
      pos_r  <= '0;
    end else if (accept) begin
      if (row_end_in) begin
        unit_r <= '0;
        row_r  <= frame_end_in ? '0 : row_r + 1'b1;
      end else begin
        unit_r <= unit_r + 1'b1;
      end
      pos_r <= frame_end_in ? '0 : pos_r + 1'b1;
    end
  end

  // compare stage
  logic          s1_valid_r, s1_rowend_r, s1_lastrow_r, s1_odd_r;
  logic [15:0]   s1_lo_r, s1_hi_r;
  logic [AW-1:0] s1_addr_r;
  logic [UW-1:0] s1_unit_r;
  logic [RW-1:0] s1_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_lo_r      <= in_ch.data.pixel_unit[15:0];
      s1_hi_r      <= in_ch.data.pixel_unit[31:16];
      s1_addr_r    <= rd_addr;
      s1_odd_r     <= pos_r[0];
      s1_unit_r    <= unit_r;
      s1_row_r     <= row_r;
      s1_rowend_r  <= row_end_in;
      s1_lastrow_r <= frame_end_in;
    end
  end

  logic [15:0]   q0, q1, rd0, rd1, wd0, wd1;
  logic          we0, we1, s1_we0, s1_we1, diff;
  logic [AW-1:0] waddr;
  logic [1:0]    fw_we_r;
  logic [AW-1:0] fw_addr_r;
  logic [15:0]   fw_d0_r, fw_d1_r;

  assign s1_we0 = s1_valid_r && (!depth_mode_r || !s1_odd_r);
  assign s1_we1 = s1_valid_r && (!depth_mode_r || s1_odd_r);
  assign we0    = clr_done_r ? s1_we0 : 1'b1;
  assign we1    = clr_done_r ? s1_we1 : 1'b1;
  assign waddr  = clr_done_r ? s1_addr_r : clr_cnt_r;
  assign wd0    = clr_done_r ? s1_lo_r : '1;
  assign wd1    = clr_done_r ? (depth_mode_r ? s1_lo_r : s1_hi_r) : '1;

  dwt_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_bank0 (
    .clk(clk), .we(we0), .waddr(waddr), .wdata(wd0), .raddr(rd_addr), .rdata(q0)
  );

  dwt_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_bank1 (
    .clk(clk), .we(we1), .waddr(waddr), .wdata(wd1), .raddr(rd_addr), .rdata(q1)
  );

  // forward the write made in the cycle of this unit's read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_we_r <= 2'b00;
    end else begin
      fw_we_r <= {s1_we1, s1_we0};
    end
  end

  always_ff @(posedge clk) begin
    fw_addr_r <= s1_addr_r;
    fw_d0_r   <= wd0;
    fw_d1_r   <= wd1;
  end

  always_comb begin
    rd0  = (fw_we_r[0] && fw_addr_r == s1_addr_r) ? fw_d0_r : q0;
    rd1  = (fw_we_r[1] && fw_addr_r == s1_addr_r) ? fw_d1_r : q1;
    diff = depth_mode_r ? (s1_odd_r ? (rd1 != s1_lo_r) : (rd0 != s1_lo_r))
                        : ((rd0 != s1_lo_r) || (rd1 != s1_hi_r));
  end

  // row box, units rise within a row
  logic          rb_has_r, rb_has_nxt;
  logic [UW-1:0] rb_first_r, rb_last_r, rb_first_nxt, rb_last_nxt;

  always_comb begin
    rb_has_nxt   = rb_has_r || diff;
    rb_first_nxt = rb_has_r ? rb_first_r : s1_unit_r;
    rb_last_nxt  = diff ? s1_unit_r : rb_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      rb_has_r <= 1'b0;
    end else if (s1_valid_r) begin
      rb_has_r <= s1_rowend_r ? 1'b0 : rb_has_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      rb_first_r <= rb_first_nxt;
      rb_last_r  <= rb_last_nxt;
    end
  end

  // merge stage
  logic          m_valid_r, m_has_r, m_lastrow_r;
  logic [UW-1:0] m_first_r, m_last_r;
  logic [RW-1:0] m_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= s1_valid_r && s1_rowend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_rowend_r) begin
      m_has_r     <= rb_has_nxt;
      m_first_r   <= rb_first_nxt;
      m_last_r    <= rb_last_nxt;
      m_row_r     <= s1_row_r;
      m_lastrow_r <= s1_lastrow_r;
    end
  end

  // accumulated box
  logic          a_has_r;
  logic [UW-1:0] a_first_r, a_last_r;
  logic [RW-1:0] a_frow_r, a_lrow_r;
  logic          c1_valid_r, c1_lastrow_r;
  logic [RW-1:0] c1_row_r;
  logic          c2_valid_r, c2_lastrow_r, c2_go, emit, page_hit;
  logic [UW-1:0] c2_sx_r;
  logic [RW-1:0] c2_rows_r;
  logic [DW-1:0] c2_c0_r, c2_c1_r;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      a_has_r <= 1'b0;
    end else if (m_valid_r && m_has_r) begin
      a_has_r <= 1'b1;
    end else if (c2_go && emit) begin
      a_has_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (m_valid_r && m_has_r) begin
      a_first_r <= (a_has_r && a_first_r < m_first_r) ? a_first_r : m_first_r;
      a_last_r  <= (a_has_r && a_last_r > m_last_r) ? a_last_r : m_last_r;
      a_frow_r  <= a_has_r ? a_frow_r : m_row_r;
      a_lrow_r  <= m_row_r;
    end
  end

  // window check: spans and columns
  logic [UW-1:0] span;
  logic [DW-1:0] sx3, c0_d3, c1_d3, c0_x2, c1_x2;

  always_comb begin
    span  = a_last_r - a_first_r + 1'b1;
    sx3   = div3((DW'(span) << 1) + DW'(2));
    c0_x2 = DW'(a_first_r) << 1;
    c1_x2 = (DW'(a_last_r) << 1) + DW'(1);
    c0_d3 = div3(c0_x2);
    c1_d3 = div3(c1_x2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_valid_r <= 1'b0;
      c2_valid_r <= 1'b0;
    end else begin
      c1_valid_r <= m_valid_r;
      c2_valid_r <= c1_valid_r || (c2_valid_r && !c2_go);
    end
  end

  always_ff @(posedge clk) begin
    if (m_valid_r) begin
      c1_row_r     <= m_row_r;
      c1_lastrow_r <= m_lastrow_r;
    end
    if (c1_valid_r) begin
      c2_sx_r      <= depth_mode_r ? UW'(sx3) : span;
      c2_rows_r    <= c1_row_r - a_frow_r + 1'b1;
      c2_c0_r      <= depth_mode_r ? c0_d3 : c0_x2;
      c2_c1_r      <= depth_mode_r ? c1_d3 : c1_x2;
      c2_lastrow_r <= c1_lastrow_r;
    end
  end

  // window check: byte estimate and emit
  logic [UW+RW-1:0] area;
  logic [BW-1:0]    bytes;
  logic             out_valid_r;
  out_item_t        out_q_r;

  always_comb begin
    area     = (UW + RW)'(c2_sx_r) * (UW + RW)'(c2_rows_r);
    bytes    = depth_mode_r ? (BW'(area) + (BW'(area) << 1)) : (BW'(area) << 2);
    page_hit = CMPW'(bytes) >= CMPW'(PAGE_BYTES);
    emit     = c2_valid_r && a_has_r && (page_hit || c2_lastrow_r);
    c2_go    = !emit || !out_valid_r || out_ch.ready;
  end

  assign chk_busy = (s1_valid_r && s1_rowend_r) || m_valid_r || c1_valid_r || c2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (c2_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c2_go && emit) begin
      out_q_r.row_start <= 10'(a_frow_r) + 10'(row_offset_r);
      out_q_r.row_end   <= 10'(a_lrow_r) + 10'(row_offset_r);
      out_q_r.col_start <= 10'(c2_c0_r) + 10'(col_offset_r);
      out_q_r.col_end   <= 10'(c2_c1_r) + 10'(col_offset_r);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_q_r;

  a_one_check: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({s1_valid_r && s1_rowend_r, m_valid_r, c1_valid_r, c2_valid_r}))
    else $error("overlapping window checks");

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(c2_valid_r))
    else $error("result without window check");

  a_no_cmp_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> clr_done_r)
    else $error("compare during clearing pass");

endmodule

@@ rtl/core/dwt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dwt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
